/* rtl/core/csgl_pkg.sv */
// Package for the cross-section grid lookup core: widths, codes, state type,
// controller/datapath command and status structs. No dependencies.
package csgl_pkg;

   localparam int unsigned GridDepthDef  = 16384;
   localparam int unsigned TableDepthDef = 16384;

   localparam int unsigned EW   = 48;   // energy width
   localparam int unsigned XW   = 32;   // cross-section width
   localparam int unsigned IW   = 14;   // index field width
   localparam int unsigned CW   = 15;   // count field width
   localparam int unsigned FW   = 17;   // fraction width
   localparam int unsigned QW   = 16;   // fraction bits

   typedef enum logic [1:0] {
      ACT_WR_GRID  = 2'd0,
      ACT_WR_TABLE = 2'd1,
      ACT_LOOKUP   = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_INTERP = 2'd0,
      REG_BELOW  = 2'd1,
      REG_BEYOND = 2'd2,
      REG_RSVD   = 2'd3
   } region_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST_RD,   // read grid point 0
      ST_LAST_RD,    // read grid point n-1
      ST_SEARCH_RD,  // read grid point mid
      ST_SEARCH_CMP, // compare and narrow
      ST_E0_RD,
      ST_E1_RD,
      ST_DIV,
      ST_TAB_LO_RD,
      ST_TAB_HI_RD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;       // capture request beat
      logic       rd_first;   // issue grid read index 0
      logic       rd_last;    // issue grid read index n-1
      logic       rd_mid;     // issue grid read index mid
      logic       cap_first;  // capture grid read data as first point
      logic       cap_last;
      logic       narrow;     // binary search step
      logic       rd_e0;      // issue read at bin (after clamp)
      logic       rd_e1;
      logic       cap_e0;
      logic       cap_e1;
      logic       div_start;
      logic       div_step;
      logic       rd_tlo;
      logic       rd_thi;
      logic       cap_tlo;
      logic       cap_thi;
      logic       mul_lo;
      logic       mul_hi;
      logic       finish;     // form result into output register
   } cmd_type;

   typedef struct packed {
      logic bad;          // slice too short
      logic search_done;  // lo == hi
      logic div_done;
      logic interp;       // bin inside table
      logic beyond;       // needs last table value
      logic tab_empty;
   } sts_type;

endpackage

/* rtl/core/cross_section_grid_lookup_core.sv */
// Cross-section grid lookup core: top level joining controller and datapath.
// An interpolated lookup runs a binary search of up to ceil(log2 n) steps, at most 14,
// then a 16-step divider; below threshold the table reads and multiply are skipped,
// beyond table only the last table value is read, and a short slice goes straight to
// output. One lookup in flight; the next beat is taken in idle once the result is
// registered, and a waiting result stalls the following lookup. Synchronous reset
// clears control state; pool contents are not cleared and are undefined until written.
module cross_section_grid_lookup_core #(
   parameter int unsigned GRID_DEPTH  = csgl_pkg::GridDepthDef,
   parameter int unsigned TABLE_DEPTH = csgl_pkg::TableDepthDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [csgl_pkg::IW-1:0]  req_address,
   input  logic [csgl_pkg::EW-1:0]  req_load_value,
   input  logic [csgl_pkg::EW-1:0]  req_energy,
   input  logic [csgl_pkg::IW-1:0]  req_grid_start,
   input  logic [csgl_pkg::CW-1:0]  req_grid_count,
   input  logic [csgl_pkg::IW-1:0]  req_table_start,
   input  logic [csgl_pkg::CW-1:0]  req_table_count,
   input  logic [csgl_pkg::IW-1:0]  req_threshold_index,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [csgl_pkg::XW-1:0]  rsp_cross_section,
   output logic [csgl_pkg::IW-1:0]  rsp_grid_bin,
   output logic [csgl_pkg::FW-1:0]  rsp_fraction,
   output logic [1:0]               rsp_region,
   output logic                     rsp_out_of_grid,
   output logic                     rsp_bad_slice
);

   csgl_pkg::cmd_type cmd;
   csgl_pkg::sts_type sts;
   logic busy, out_full, out_taken, acc;

   // beat accepted only while controller idle
   assign req_stall = busy;
   assign acc       = req_valid && !busy;
   assign out_taken = out_full && !rsp_stall;
   assign rsp_valid = out_full;

   csgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (acc && (req_action == csgl_pkg::ACT_LOOKUP)),
      .out_taken (out_taken),
      .out_full  (out_full),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   csgl_dpath #(.GRID_DEPTH(GRID_DEPTH), .TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .wr_grid         (acc && (req_action == csgl_pkg::ACT_WR_GRID)),
      .wr_table        (acc && (req_action == csgl_pkg::ACT_WR_TABLE)),
      .address         (req_address),
      .load_value      (req_load_value),
      .energy          (req_energy),
      .grid_start      (req_grid_start),
      .grid_count      (req_grid_count),
      .table_start     (req_table_start),
      .table_count     (req_table_count),
      .threshold_index (req_threshold_index),
      .out_taken       (out_taken),
      .out_full        (out_full),
      .cross_section   (rsp_cross_section),
      .grid_bin        (rsp_grid_bin),
      .fraction        (rsp_fraction),
      .region          (rsp_region),
      .out_of_grid     (rsp_out_of_grid),
      .bad_slice       (rsp_bad_slice)
   );

endmodule

/* rtl/core/csgl_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module csgl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/csgl_ctrl.sv */
// Controller state machine for the lookup sequence.
// Depends on csgl_pkg.
module csgl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,     // lookup beat accepted
   input  logic                out_taken, // result beat leaves output register
   input  logic                out_full,
   input  csgl_pkg::sts_type   sts,
   output csgl_pkg::cmd_type   cmd,
   output logic                busy
);

   csgl_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csgl_pkg::ST_IDLE:       if (start) state_in = csgl_pkg::ST_FIRST_RD;
         csgl_pkg::ST_FIRST_RD: begin
            if (sts.bad) state_in = csgl_pkg::ST_OUT;
            else         state_in = csgl_pkg::ST_LAST_RD;
         end
         csgl_pkg::ST_LAST_RD: begin
            if (sts.search_done) state_in = csgl_pkg::ST_E0_RD;
            else                 state_in = csgl_pkg::ST_SEARCH_RD;
         end
         csgl_pkg::ST_SEARCH_RD:  state_in = csgl_pkg::ST_SEARCH_CMP;
         csgl_pkg::ST_SEARCH_CMP: begin
            if (sts.search_done) state_in = csgl_pkg::ST_E0_RD;
            else                 state_in = csgl_pkg::ST_SEARCH_RD;
         end
         csgl_pkg::ST_E0_RD:      state_in = csgl_pkg::ST_E1_RD;
         csgl_pkg::ST_E1_RD:      state_in = csgl_pkg::ST_DIV;
         csgl_pkg::ST_DIV: begin
            if (sts.div_done) begin
               if (sts.interp)      state_in = csgl_pkg::ST_TAB_LO_RD;
               else if (sts.beyond) state_in = csgl_pkg::ST_TAB_HI_RD;
               else                 state_in = csgl_pkg::ST_OUT;
            end
         end
         csgl_pkg::ST_TAB_LO_RD:  state_in = csgl_pkg::ST_TAB_HI_RD;
         csgl_pkg::ST_TAB_HI_RD: begin
            if (sts.interp) state_in = csgl_pkg::ST_MUL_LO;
            else            state_in = csgl_pkg::ST_OUT;
         end
         csgl_pkg::ST_MUL_LO:     state_in = csgl_pkg::ST_MUL_HI;
         csgl_pkg::ST_MUL_HI:     state_in = csgl_pkg::ST_OUT;
         csgl_pkg::ST_OUT: begin
            if (!out_full || out_taken) state_in = csgl_pkg::ST_IDLE;
         end
         default:                 state_in = csgl_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = (state_ff != csgl_pkg::ST_IDLE);
      case (state_ff)
         csgl_pkg::ST_IDLE: begin
            cmd.load     = start;
            cmd.rd_first = start;
         end
         csgl_pkg::ST_FIRST_RD: begin
            cmd.cap_first = 1'b1;
            cmd.rd_last   = 1'b1;
         end
         csgl_pkg::ST_LAST_RD: begin
            cmd.cap_last = 1'b1;
            cmd.rd_mid   = !sts.search_done;
         end
         // hold the mid address so the read data stays on mid
         csgl_pkg::ST_SEARCH_RD:  cmd.rd_mid = 1'b1;
         csgl_pkg::ST_SEARCH_CMP: begin
            cmd.narrow = 1'b1;
            cmd.rd_mid = 1'b1;
         end
         csgl_pkg::ST_E0_RD:      cmd.rd_e0 = 1'b1;
         csgl_pkg::ST_E1_RD: begin
            cmd.cap_e0 = 1'b1;
            cmd.cap_e1 = 1'b1;
            cmd.rd_e1  = 1'b1;
         end
         csgl_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.rd_tlo   = sts.div_done;
            cmd.rd_thi   = sts.div_done && !sts.interp;
         end
         csgl_pkg::ST_TAB_LO_RD: begin
            cmd.cap_tlo = 1'b1;
            cmd.rd_thi  = 1'b1;
         end
         csgl_pkg::ST_TAB_HI_RD:  cmd.cap_thi = 1'b1;
         csgl_pkg::ST_MUL_LO:     cmd.mul_lo = 1'b1;
         csgl_pkg::ST_MUL_HI:     cmd.mul_hi = 1'b1;
         csgl_pkg::ST_OUT:        cmd.finish = !out_full || out_taken;
         default: ;
      endcase
      cmd.div_start = (state_ff == csgl_pkg::ST_E1_RD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csgl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == csgl_pkg::ST_IDLE)
      else $error("lookup started while busy");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == csgl_pkg::ST_IDLE)
      else $error("finish did not return to idle");
   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == csgl_pkg::ST_SEARCH_RD |=> state_ff == csgl_pkg::ST_SEARCH_CMP)
      else $error("search compare skipped");
`endif

endmodule

/* rtl/core/csgl_dpath.sv */
// Datapath: pools, search registers, serial divider, interpolation multiplier
// and output register. Depends on csgl_pkg and csgl_ram.
module csgl_dpath #(
   parameter int unsigned GRID_DEPTH  = csgl_pkg::GridDepthDef,
   parameter int unsigned TABLE_DEPTH = csgl_pkg::TableDepthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  csgl_pkg::cmd_type           cmd,
   output csgl_pkg::sts_type           sts,
   // load path
   input  logic                        wr_grid,
   input  logic                        wr_table,
   input  logic [csgl_pkg::IW-1:0]     address,
   input  logic [csgl_pkg::EW-1:0]     load_value,
   // lookup fields
   input  logic [csgl_pkg::EW-1:0]     energy,
   input  logic [csgl_pkg::IW-1:0]     grid_start,
   input  logic [csgl_pkg::CW-1:0]     grid_count,
   input  logic [csgl_pkg::IW-1:0]     table_start,
   input  logic [csgl_pkg::CW-1:0]     table_count,
   input  logic [csgl_pkg::IW-1:0]     threshold_index,
   // result
   input  logic                        out_taken,
   output logic                        out_full,
   output logic [csgl_pkg::XW-1:0]     cross_section,
   output logic [csgl_pkg::IW-1:0]     grid_bin,
   output logic [csgl_pkg::FW-1:0]     fraction,
   output logic [1:0]                  region,
   output logic                        out_of_grid,
   output logic                        bad_slice
);

   localparam int unsigned GA = $clog2(GRID_DEPTH);
   localparam int unsigned TA = $clog2(TABLE_DEPTH);
   localparam int unsigned NW = GA + 1;   // count up to GRID_DEPTH
   localparam int unsigned EW = csgl_pkg::EW;
   localparam int unsigned XW = csgl_pkg::XW;
   localparam int unsigned QW = csgl_pkg::QW;
   localparam int unsigned FW = csgl_pkg::FW;
   // signed bin offset
   localparam int unsigned JW = ((NW > csgl_pkg::CW) ? NW : csgl_pkg::CW) + 2;

   // lookup operands
   logic [EW-1:0] e_ff;
   logic [GA-1:0] gs_ff;
   logic [NW-1:0] n_ff;
   logic [TA-1:0] ts_ff;
   logic [csgl_pkg::CW-1:0] tn_ff;
   logic [csgl_pkg::IW-1:0] thr_ff;
   logic [NW-1:0] n_sat;
   logic [NW-1:0] gcnt;

   // search
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid, bin;
   logic          oog_ff, oog_in, below_first_ff;
   logic [EW-1:0] e0_ff, e1_ff;

   // memories
   logic [GA-1:0] g_rd_addr;
   logic [EW-1:0] g_rd_data;
   logic [TA-1:0] t_rd_addr;
   logic [XW-1:0] t_rd_data;
   logic [XW-1:0] xlo_ff, xhi_ff;

   // divider
   logic [EW:0]      rem_ff;
   logic [EW:0]      rem_sh, rem_sub;
   logic [EW-1:0]    den_ff;
   logic [QW:0]      quo_ff;
   logic [4:0]       dcnt_ff;
   logic [FW-1:0]    frac_ff;
   logic             div_busy_ff;

   // interpolation
   logic signed [JW-1:0] j;
   logic [TA-1:0]        j_idx;
   logic [XW+FW-1:0]     acc_ff;
   logic [XW+FW-1:0]     prod;
   logic [FW-1:0]        mul_f;
   logic [XW-1:0]        mul_x;

   // output register
   logic                 full_ff;
   logic [XW-1:0]        xs_ff;
   logic [csgl_pkg::IW-1:0] bin_ff;
   logic [FW-1:0]        fr_ff;
   logic [1:0]           reg_ff;
   logic                 oogo_ff, bad_ff;

   // count saturation
   assign gcnt  = (NW > csgl_pkg::CW) ? NW'(grid_count)
                                      : NW'(grid_count[csgl_pkg::CW-1:0]);
   assign n_sat = (32'(grid_count) > GRID_DEPTH) ? NW'(GRID_DEPTH) : gcnt;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff   <= energy;
         gs_ff  <= GA'(grid_start);
         n_ff   <= n_sat;
         ts_ff  <= TA'(table_start);
         tn_ff  <= table_count;
         thr_ff <= threshold_index;
      end
   end

   // grid read address
   assign mid = lo_ff + ((hi_ff - lo_ff + NW'(1)) >> 1);
   always_comb begin
      g_rd_addr = gs_ff;
      if (cmd.rd_first)      g_rd_addr = GA'(grid_start);
      else if (cmd.rd_last)  g_rd_addr = gs_ff + GA'(n_ff - NW'(1));
      else if (cmd.rd_e1)    g_rd_addr = gs_ff + GA'(bin + NW'(1));
      else if (cmd.narrow)   g_rd_addr = gs_ff + GA'(lo_in + ((hi_in - lo_in + NW'(1)) >> 1));
      else if (cmd.rd_mid)   g_rd_addr = gs_ff + GA'(mid);
      else if (cmd.rd_e0)    g_rd_addr = gs_ff + GA'(bin);
      else                   g_rd_addr = gs_ff + GA'(bin);
   end

   csgl_ram #(.WIDTH(EW), .DEPTH(GRID_DEPTH)) u_grid (
      .clock   (clock),
      .wr_en   (wr_grid && (32'(address) < GRID_DEPTH)),
      .wr_addr (GA'(address)),
      .wr_data (load_value),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   // binary search; starts at lo=0 hi=n-1, so lo==hi at load when n is 1
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      oog_in = oog_ff;
      if (cmd.narrow) begin
         if (g_rd_data <= e_ff) lo_in = mid;
         else                   hi_in = mid - NW'(1);
      end
   end

   assign bin = (lo_ff >= n_ff - NW'(1)) ? n_ff - NW'(2) : lo_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff <= '0;
         hi_ff <= n_sat - NW'(1);
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.cap_first) below_first_ff <= (e_ff < g_rd_data);
      if (cmd.cap_last)  oog_ff <= below_first_ff || (e_ff > g_rd_data);
      if (cmd.cap_e0)    e0_ff <= g_rd_data;
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh  = {rem_ff[EW-1:0], 1'b0};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.cap_e1) begin
         div_busy_ff <= 1'b1;
      end else if (cmd.div_step && !div_init_ff && dcnt_ff == 5'd0) begin
         div_busy_ff <= 1'b0;
      end
   end

   // e0 read in E0_RD, e1 read in E1_RD; e1 data arrives in DIV's first cycle
   logic div_init_ff;
   always_ff @(posedge clock) begin
      if (reset) div_init_ff <= 1'b0;
      else       div_init_ff <= cmd.div_start;
   end

   // inside the bin (e-e0) < (e1-e0), so 16 steps give the whole quotient
   always_ff @(posedge clock) begin
      if (div_init_ff) begin
         e1_ff   <= g_rd_data;
         den_ff  <= g_rd_data - e0_ff;
         rem_ff  <= {1'b0, e_ff - e0_ff};
         quo_ff  <= '0;
         dcnt_ff <= 5'(QW);
      end else if (cmd.div_step && dcnt_ff != 5'd0) begin
         if (!rem_sub[EW]) begin
            rem_ff <= rem_sub;
            quo_ff <= {quo_ff[QW-1:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QW-1:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   assign sts.div_done = div_busy_ff && !div_init_ff && dcnt_ff == 5'd0;

   always_comb begin
      if (e1_ff <= e0_ff || e_ff <= e0_ff) frac_ff = '0;
      else if (e_ff >= e1_ff)             frac_ff = FW'(1 << QW);
      else                                frac_ff = FW'(quo_ff[QW-1:0]);
   end

   // bin relative to threshold
   assign j     = JW'(signed'({1'b0, bin})) - JW'(signed'({1'b0, thr_ff}));
   assign j_idx = ts_ff + TA'(j);
   assign sts.interp = !j[JW-1] && (j < JW'(signed'({1'b0, tn_ff})) - JW'(1));
   assign sts.beyond = !j[JW-1] && !sts.interp;
   assign sts.tab_empty = (tn_ff == '0);
   assign sts.bad = (n_ff < NW'(2));
   assign sts.search_done = (lo_in == hi_in);

   always_comb begin
      t_rd_addr = j_idx;
      if (cmd.rd_thi) begin
         if (sts.interp) t_rd_addr = j_idx + TA'(1);
         else            t_rd_addr = ts_ff + TA'(tn_ff - csgl_pkg::CW'(1));
      end
   end

   csgl_ram #(.WIDTH(XW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_table && (32'(address) < TABLE_DEPTH)),
      .wr_addr (TA'(address)),
      .wr_data (load_value[XW-1:0]),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap_tlo) xlo_ff <= t_rd_data;
      if (cmd.cap_thi) xhi_ff <= t_rd_data;
   end

   // two products, one per cycle, summed
   assign mul_f = cmd.mul_lo ? FW'(1 << QW) - frac_ff : frac_ff;
   assign mul_x = cmd.mul_lo ? xlo_ff : xhi_ff;
   assign prod  = (XW+FW)'(mul_x) * (XW+FW)'(mul_f);

   always_ff @(posedge clock) begin
      if (cmd.mul_lo)      acc_ff <= prod;
      else if (cmd.mul_hi) acc_ff <= acc_ff + prod;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (cmd.finish) begin
         full_ff <= 1'b1;
      end else if (out_taken) begin
         full_ff <= 1'b0;
      end
      if (cmd.finish) begin
         bad_ff <= sts.bad;
         if (sts.bad) begin
            xs_ff   <= '0;
            bin_ff  <= '0;
            fr_ff   <= '0;
            reg_ff  <= csgl_pkg::REG_BELOW;
            oogo_ff <= 1'b0;
         end else begin
            bin_ff  <= csgl_pkg::IW'(bin);
            fr_ff   <= frac_ff;
            oogo_ff <= oog_ff;
            if (j[JW-1]) begin
               xs_ff  <= '0;
               reg_ff <= csgl_pkg::REG_BELOW;
            end else if (sts.interp) begin
               xs_ff  <= acc_ff[QW+XW-1:QW];
               reg_ff <= csgl_pkg::REG_INTERP;
            end else begin
               xs_ff  <= sts.tab_empty ? '0 : xhi_ff;
               reg_ff <= csgl_pkg::REG_BEYOND;
            end
         end
      end
   end

   assign out_full      = full_ff;
   assign cross_section = xs_ff;
   assign grid_bin      = bin_ff;
   assign fraction      = fr_ff;
   assign region        = reg_ff;
   assign out_of_grid   = oogo_ff;
   assign bad_slice     = bad_ff;

`ifndef SYNTHESIS
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> fr_ff <= FW'(1 << QW))
      else $error("fraction above one");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (full_ff && bad_ff) |-> (xs_ff == '0 && fr_ff == '0))
      else $error("bad slice result not cleared");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.narrow |-> lo_ff < hi_ff)
      else $error("search step with empty range");
`endif

endmodule
